@@ hdl/mtp_pkg.sv @@
// shared types and constants for the pulmonary twister generator
// no dependencies
package mtp_pkg;
	localparam logic [1:0] KIND_SEED = 2'd0;
	localparam logic [1:0] KIND_D32  = 2'd1;
	localparam logic [1:0] KIND_D64  = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_UNSEED = 2'd1;
	localparam logic [1:0] ST_ODD    = 2'd2;

	localparam logic [2:0] REG_MASK0   = 3'd0;
	localparam logic [2:0] REG_MASK1   = 3'd1;
	localparam logic [2:0] REG_MASK2   = 3'd2;
	localparam logic [2:0] REG_MASK3   = 3'd3;
	localparam logic [2:0] REG_PARITY0 = 3'd4;
	localparam logic [2:0] REG_PARITY1 = 3'd5;
	localparam logic [2:0] REG_PARITY2 = 3'd6;
	localparam logic [2:0] REG_PARITY3 = 3'd7;

	localparam logic [7:0]  SHUFFLE_CODE = 8'h4B;
	localparam logic [31:0] SEED_MULT    = 32'd1812433253;

	typedef logic [3:0][31:0] word128_t;

	// lung lane picked for lane k
	function automatic logic [1:0] shuf_sel(input int k);
		return 2'((SHUFFLE_CODE >> (2 * k)) & 8'h3);
	endfunction
endpackage

@@ hdl/mtp_if.sv @@
// valid/ready channel interfaces for the generator
// depends on nothing
interface mtp_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] seed_value;
	modport source (output valid, kind, seed_value, input ready);
	modport sink (input valid, kind, seed_value, output ready);
endinterface

interface mtp_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] random_value;
	logic [1:0]  draw_status;
	modport source (output valid, random_value, draw_status, input ready);
	modport sink (input valid, random_value, draw_status, output ready);
endinterface

interface mtp_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/mtp_ram.sv @@
// generic single write, single read ram with registered read data
// depends on nothing
module mtp_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 155
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ hdl/mtp_step.sv @@
// recursion unit: one new state word from a, b, previous word and lung
// depends on mtp_pkg
module mtp_step #(
	parameter int LANE_LEFT_SHIFT = 18,
	parameter int BYTE_LEFT_SHIFT = 1,
	parameter int B_RIGHT_SHIFT   = 11,
	parameter int C_RIGHT_SHIFT   = 1
) (
	input  mtp_pkg::word128_t a,
	input  mtp_pkg::word128_t b,
	input  mtp_pkg::word128_t c,
	input  mtp_pkg::word128_t d,
	input  mtp_pkg::word128_t mask,
	output mtp_pkg::word128_t r
);
	import mtp_pkg::*;

	logic [127:0] x;

	assign x = 128'(a) << (8 * BYTE_LEFT_SHIFT);

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			r[k] = (c[k] >> C_RIGHT_SHIFT) ^ (c[k] << LANE_LEFT_SHIFT) ^ d[shuf_sel(k)]
				^ a[k] ^ x[32*k +: 32] ^ ((b[k] >> B_RIGHT_SHIFT) & mask[k]);
		end
	end
endmodule

@@ hdl/pulmonary_mersenne_twister_prng_top.sv @@
// top level of the pulmonary twister generator: sequencer, lung, registers
// depends on mtp_pkg, mtp_if, mtp_ram, mtp_step
//
// usage: in_ch carries kind and seed_value; kind reseed fills the state and
// gives no word, kind draw gives one word on out_ch (32-bit in the low half,
// or 64-bit low lane first) with a draw_status. cfg writes the four mask and
// four parity registers, index 0..7; cfg.ready is always high, write only idle.
// a draw from a ready buffer goes through S_RD, S_RDW and S_OUT to its word;
// a draw that hits the end of the buffer first regenerates STATE_WORDS words,
// each through S_RA, S_RB and S_WR, as the single ram read port reads the
// a and b words in turn. a reseed runs S_SEED, S_ADD per 32-bit lane for the
// seed multiply then add. one item at a time; in_ch.ready is low while busy.
// the result sits in an output register; if out_ch stalls, the block waits
// with the next result until it is taken. reset clears the sequencer, the
// read index and the seeded flag, and loads the register defaults; the ram
// holds nothing valid until the first reseed.
module pulmonary_mersenne_twister_prng_top #(
	parameter int STATE_WORDS     = 155,
	parameter int PICKUP_OFFSET   = 122,
	parameter int LANE_LEFT_SHIFT = 18,
	parameter int BYTE_LEFT_SHIFT = 1,
	parameter int B_RIGHT_SHIFT   = 11,
	parameter int C_RIGHT_SHIFT   = 1
) (
	input  logic      clk,
	input  logic      arst_n,
	mtp_in_if.sink    in_ch,
	mtp_out_if.source out_ch,
	mtp_cfg_if.sink   cfg
);
	import mtp_pkg::*;

	localparam int AW     = $clog2(STATE_WORDS);
	localparam int IDX_W  = $clog2(4 * STATE_WORDS + 1);
	localparam int SI_W   = $clog2(4 * (STATE_WORDS + 1));
	localparam int B_INIT = PICKUP_OFFSET % STATE_WORDS;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SEED = 4'd1;
	localparam logic [3:0] S_ADD  = 4'd2;
	localparam logic [3:0] S_CERT = 4'd3;
	localparam logic [3:0] S_RA   = 4'd4;
	localparam logic [3:0] S_RB   = 4'd5;
	localparam logic [3:0] S_WR   = 4'd6;
	localparam logic [3:0] S_RD   = 4'd7;
	localparam logic [3:0] S_RDW  = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	logic [3:0]       state_q;
	logic [1:0]       kind_q;
	logic [IDX_W-1:0] idx_q;
	logic             seeded_q;
	logic [SI_W-1:0]  si_q;
	logic [31:0]      prev_q;
	logic [31:0]      mul_q;
	logic [95:0]      lbuf_q;
	logic [AW-1:0]    gi_q;
	logic [AW-1:0]    gb_q;
	word128_t         a_q;
	word128_t         c_q;
	word128_t         lung_q;
	word128_t         mask_q;
	word128_t         par_q;
	logic             ov_q;
	logic [63:0]      oval_q;
	logic [1:0]       ost_q;
	logic [63:0]      res_val_q;
	logic [1:0]       res_st_q;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [127:0]     wdata;
	logic [AW-1:0]    raddr;
	word128_t         rdata;
	word128_t         new_w;
	logic [SI_W-3:0]  seed_word;
	logic [127:0]     par_flat;
	logic [127:0]     low_bit;

	assign seed_word = si_q[SI_W-1:2];
	assign par_flat  = par_q;
	assign low_bit   = par_flat & (~par_flat + 128'd1);

	mtp_ram #(.WIDTH(128), .DEPTH(STATE_WORDS)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	mtp_step #(
		.LANE_LEFT_SHIFT(LANE_LEFT_SHIFT),
		.BYTE_LEFT_SHIFT(BYTE_LEFT_SHIFT),
		.B_RIGHT_SHIFT  (B_RIGHT_SHIFT),
		.C_RIGHT_SHIFT  (C_RIGHT_SHIFT)
	) u_step (
		.a   (a_q),
		.b   (rdata),
		.c   (c_q),
		.d   (lung_q),
		.mask(mask_q),
		.r   (new_w)
	);

	always_comb begin
		we    = 1'b0;
		waddr = gi_q;
		wdata = new_w;
		raddr = AW'(idx_q >> 2);
		case (state_q)
			S_SEED: begin
				if (si_q[1:0] == 2'd3 && seed_word < (SI_W-2)'(STATE_WORDS)) begin
					we = 1'b1;
				end
				waddr = AW'(seed_word);
				wdata = {prev_q, lbuf_q};
			end
			S_RA: raddr = gi_q;
			S_RB: raddr = gb_q;
			S_WR: we = 1'b1;
			default: ;
		endcase
	end

	assign in_ch.ready   = (state_q == S_IDLE);
	assign cfg.ready     = 1'b1;
	assign out_ch.valid  = ov_q;
	assign out_ch.random_value = oval_q;
	assign out_ch.draw_status  = ost_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= {32'd3221225462, 32'd3220897791, 32'd3724462975, 32'd3758096367};
			par_q  <= {32'd331998852, 32'd0, 32'd0, 32'd1};
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MASK0:   mask_q[0] <= cfg.data;
				REG_MASK1:   mask_q[1] <= cfg.data;
				REG_MASK2:   mask_q[2] <= cfg.data;
				REG_MASK3:   mask_q[3] <= cfg.data;
				REG_PARITY0: par_q[0]  <= cfg.data;
				REG_PARITY1: par_q[1]  <= cfg.data;
				REG_PARITY2: par_q[2]  <= cfg.data;
				REG_PARITY3: par_q[3]  <= cfg.data;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == S_OUT && (!ov_q || out_ch.ready)) begin
			ov_q <= 1'b1;
		end else if (out_ch.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!ov_q || out_ch.ready)) begin
			oval_q <= res_val_q;
			ost_q  <= res_st_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			seeded_q <= 1'b0;
			kind_q   <= KIND_SEED;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						kind_q <= in_ch.kind;
						if (in_ch.kind == KIND_SEED) begin
							state_q <= S_SEED;
						end else if (in_ch.kind == KIND_D64 && !seeded_q) begin
							state_q <= S_OUT;
						end else if (in_ch.kind == KIND_D64 && idx_q[0]) begin
							state_q <= S_OUT;
						end else if (in_ch.kind == KIND_D32 || in_ch.kind == KIND_D64) begin
							if (idx_q >= IDX_W'(4 * STATE_WORDS)) begin
								state_q <= S_RA;
							end else begin
								state_q <= S_RD;
							end
						end
					end
				end
				S_SEED: begin
					if (si_q == SI_W'(4 * (STATE_WORDS + 1) - 1)) begin
						state_q <= S_CERT;
					end else begin
						state_q <= S_ADD;
					end
				end
				S_ADD: state_q <= S_SEED;
				S_CERT: begin
					idx_q    <= IDX_W'(4 * STATE_WORDS);
					seeded_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_RA: state_q <= S_RB;
				S_RB: state_q <= S_WR;
				S_WR: begin
					if (gi_q == AW'(STATE_WORDS - 1)) begin
						idx_q   <= '0;
						state_q <= S_RD;
					end else begin
						state_q <= S_RA;
					end
				end
				S_RD: state_q <= S_RDW;
				S_RDW: begin
					idx_q   <= idx_q + ((kind_q == KIND_D64) ? IDX_W'(2) : IDX_W'(1));
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!ov_q || out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				prev_q    <= in_ch.seed_value;
				si_q      <= '0;
				gi_q      <= '0;
				gb_q      <= AW'(B_INIT);
				res_val_q <= '0;
				res_st_q  <= seeded_q ? ST_ODD : ST_UNSEED;
			end
			S_SEED: begin
				case (si_q[1:0])
					2'd0: lbuf_q[31:0]  <= prev_q;
					2'd1: lbuf_q[63:32] <= prev_q;
					2'd2: lbuf_q[95:64] <= prev_q;
					default: begin
						if (seed_word == (SI_W-2)'(STATE_WORDS - 1)) begin
							c_q <= {prev_q, lbuf_q};
						end
						if (seed_word == (SI_W-2)'(STATE_WORDS)) begin
							lung_q <= {prev_q, lbuf_q};
						end
					end
				endcase
				mul_q <= SEED_MULT * (prev_q ^ (prev_q >> 30));
				si_q  <= si_q + SI_W'(1);
			end
			S_ADD: prev_q <= mul_q + 32'(si_q);
			S_CERT: begin
				// even parity: flip the lowest parity bit in the lung
				if (!(^(lung_q & par_flat))) begin
					lung_q <= lung_q ^ low_bit;
				end
			end
			S_RB: a_q <= rdata;
			S_WR: begin
				c_q    <= new_w;
				lung_q <= lung_q ^ new_w;
				gi_q   <= gi_q + AW'(1);
				gb_q   <= (gb_q == AW'(STATE_WORDS - 1)) ? '0 : gb_q + AW'(1);
			end
			S_RDW: begin
				res_st_q <= ST_OK;
				if (kind_q == KIND_D64) begin
					res_val_q <= idx_q[1] ? {rdata[3], rdata[2]} : {rdata[1], rdata[0]};
				end else begin
					res_val_q <= {32'd0, rdata[idx_q[1:0]]};
				end
			end
			default: ;
		endcase
	end
endmodule
